@@ sv/clip_edge_top_plane_interp_assert.svh @@
`ifndef CLIP_EDGE_TOP_PLANE_INTERP_ASSERT_SVH
`define CLIP_EDGE_TOP_PLANE_INTERP_ASSERT_SVH
// same-cycle implication, checked outside reset
`define CETPI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, no reset gating
`define CETPI_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ sv/cetpi_pkg.sv @@
package cetpi_pkg;
    localparam int unsigned DIV_BITS   = 4;
    localparam int unsigned DIV_STAGES = 8;
    localparam logic [31:0] T_MAX = 32'h7fffffff;
    localparam logic [31:0] T_MIN = 32'h80000000;

    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] az;
        logic [31:0] ar;
        logic [31:0] dx;
        logic [31:0] dz;
        logic [31:0] dr;
        logic        sat_max;
        logic        sat_min;
        logic        neg;
        logic        cen;
    } side_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
    } div_t;

    // DIV_BITS restoring steps; remainder stays below den
    function automatic div_t div_step(div_t cur, logic [31:0] den);
        div_t        res;
        logic [32:0] r2;
        res = cur;
        for (int i = 0; i < DIV_BITS; i++) begin
            r2 = {res.rem, 1'b0};
            if (r2 >= {1'b0, den}) begin
                r2 = r2 - {1'b0, den};
                res.quo = {res.quo[30:0], 1'b1};
            end else begin
                res.quo = {res.quo[30:0], 1'b0};
            end
            res.rem = r2[31:0];
        end
        return res;
    endfunction
endpackage

@@ sv/cetpi_div.sv @@
module cetpi_div import cetpi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] in_rem,
    input  logic [31:0] in_den,
    input  side_t       in_side,
    output logic        out_valid,
    output logic [31:0] out_quo,
    output side_t       out_side
);
    logic [DIV_STAGES-1:0] v_reg;
    div_t                  acc_reg  [DIV_STAGES];
    div_t                  acc_next [DIV_STAGES];
    logic [31:0]           den_reg  [DIV_STAGES];
    side_t                 side_reg [DIV_STAGES];

    always_comb begin
        acc_next[0] = div_step('{rem: in_rem, quo: 32'd0}, in_den);
        for (int k = 1; k < DIV_STAGES; k++) begin
            acc_next[k] = div_step(acc_reg[k-1], den_reg[k-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[DIV_STAGES-2:0], in_valid};
        end
        if (en) begin
            acc_reg[0]  <= acc_next[0];
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
            for (int k = 1; k < DIV_STAGES; k++) begin
                acc_reg[k]  <= acc_next[k];
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_quo   = acc_reg[DIV_STAGES-1].quo;
    assign out_side  = side_reg[DIV_STAGES-1];
endmodule

@@ sv/clip_edge_top_plane_interp.sv @@
// Pipeline stages from input transaction to result: 1 prep, 8 divider, 1 t, 1 mul, 1 out.
// Throughput: one edge per cycle while the output is not stalled; the 32-step divider is split 4 bits per stage.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Reset (aresetn low, synchronous) clears all valid bits and the colour enable.
`include "clip_edge_top_plane_interp_assert.svh"
module clip_edge_top_plane_interp import cetpi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_a_x,
    input  logic [31:0] s_a_y,
    input  logic [31:0] s_a_z,
    input  logic [31:0] s_a_r,
    input  logic [31:0] s_b_x,
    input  logic [31:0] s_b_y,
    input  logic [31:0] s_b_z,
    input  logic [31:0] s_b_r,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_x,
    output logic [31:0] m_out_y,
    output logic [31:0] m_out_z,
    output logic [31:0] m_out_r,
    output logic        m_r_written
);
    logic        cen_reg;
    logic        en;
    logic signed [31:0] n, d, negd;
    logic        sat_max;
    side_t       side_next;
    logic        v1_reg, v_div, vt_reg, vm_reg, vo_reg;
    logic [31:0] rem1_reg, den1_reg, rem1_next, quo_div;
    side_t       side1_reg, side_div, sidet_reg, sidem_reg;
    logic [31:0] t_reg, t_next;
    logic [30:0] q;
    logic signed [63:0] px_reg, pz_reg, pr_reg;
    logic [31:0] ox_reg, oz_reg, or_reg;
    logic        ow_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cen_reg <= 1'b0;
        end else if (cfg_valid) begin
            cen_reg <= cfg_wdata;
        end
    end

    assign en      = !vo_reg || m_ready;
    assign s_ready = en;

    always_comb begin
        n       = s_a_z - s_a_y;
        d       = (s_b_y + s_a_z) - (s_a_y + s_b_z);
        negd    = -d;
        sat_max = n >= d;
        side_next.ax      = s_a_x;
        side_next.az      = s_a_z;
        side_next.ar      = s_a_r;
        side_next.dx      = s_b_x - s_a_x;
        side_next.dz      = s_b_z - s_a_z;
        side_next.dr      = s_b_r - s_a_r;
        side_next.sat_max = sat_max;
        side_next.sat_min = !sat_max && !(negd < n);
        side_next.neg     = n[31];
        side_next.cen     = cen_reg;
        rem1_next = n[31] ? -n : n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            vt_reg <= 1'b0;
            vm_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            vt_reg <= v_div;
            vm_reg <= vt_reg;
            vo_reg <= vm_reg;
        end
        if (en) begin
            rem1_reg  <= rem1_next;
            den1_reg  <= d;
            side1_reg <= side_next;
            t_reg     <= t_next;
            sidet_reg <= side_div;
            px_reg    <= $signed(sidet_reg.dx) * $signed(t_reg);
            pz_reg    <= $signed(sidet_reg.dz) * $signed(t_reg);
            pr_reg    <= $signed(sidet_reg.dr) * $signed(t_reg);
            sidem_reg <= sidet_reg;
            ox_reg    <= sidem_reg.ax + px_reg[62:31];
            oz_reg    <= sidem_reg.az + pz_reg[62:31];
            or_reg    <= sidem_reg.cen ? sidem_reg.ar + pr_reg[62:31] : 32'd0;
            ow_reg    <= sidem_reg.cen;
        end
    end

    cetpi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v1_reg),
        .in_rem    (rem1_reg),
        .in_den    (den1_reg),
        .in_side   (side1_reg),
        .out_valid (v_div),
        .out_quo   (quo_div),
        .out_side  (side_div)
    );

    // divider yields floor(|n| * 2^32 / d); drop one bit for Q1.31
    always_comb begin
        q = quo_div[31:1];
        if (side_div.sat_max) begin
            t_next = T_MAX;
        end else if (side_div.sat_min) begin
            t_next = T_MIN;
        end else if (side_div.neg) begin
            t_next = -{1'b0, q};
        end else begin
            t_next = {1'b0, q};
        end
    end

    assign m_valid     = vo_reg;
    assign m_out_x     = ox_reg;
    assign m_out_y     = oz_reg;
    assign m_out_z     = oz_reg;
    assign m_out_r     = or_reg;
    assign m_r_written = ow_reg;

    `CETPI_ASSERT_NOW(a_ready_rule, aclk, aresetn, 1'b1, s_ready == (!m_valid || m_ready))
    `CETPI_ASSERT_NOW(a_r_zero, aclk, aresetn, m_valid && !m_r_written, m_out_r == 32'd0)
    `CETPI_ASSERT_NEXT(a_reset_clear, aclk, !aresetn, !m_valid && !v1_reg)
endmodule
